// File: hw/rtl/itpa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itpa_pkg
// Shared types, codes and character constants for the integer text formatter.
// ----------------------------------------------------------------------------
package itpa_pkg;

    // Job magnitude storage; values narrower than this are zero-extended.
    localparam int MAG_W    = 32;
    localparam int CFG_W    = 7;
    localparam int CFG_IDX_W = 2;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_BASE      = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FLAGS     = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_WIDTH = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PRECISION = 2'd3;

    // Format flag bit positions
    localparam int FLAG_LOWER    = 0;
    localparam int FLAG_UNSIGNED = 1;
    localparam int FLAG_PLUS     = 2;
    localparam int FLAG_SPACE    = 3;
    localparam int FLAG_LEFT     = 4;
    localparam int FLAG_ZPAD     = 5;
    localparam int FLAG_PREC     = 6;

    localparam logic [4:0] BASE_RESET = 5'd10;
    localparam logic [4:0] BASE_MIN   = 5'd2;
    localparam logic [4:0] BASE_MAX   = 5'd16;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_PLUS  = 8'h2B;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NONE  = 8'h00;

    localparam logic [7:0] LOWER_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
    };
    localparam logic [7:0] UPPER_DIGITS [16] = '{
        8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
        8'h38, 8'h39, 8'h41, 8'h42, 8'h43, 8'h44, 8'h45, 8'h46
    };

    // One classified value, as handed from front to back.
    typedef struct packed {
        logic [MAG_W-1:0] mag;       // magnitude, zero-extended
        logic [4:0]       base;      // clamped to 2..16
        logic [5:0]       width;     // saturated minimum field width
        logic [5:0]       prec;      // effective precision, 0 when not given
        logic             skip;      // zero with precision zero: no digits
        logic             has_sign;  // a sign character is printed
        logic [7:0]       sign_ch;
        logic             slot;      // one width slot reserved for the sign
        logic             left;
        logic             zpad;      // zero pad, right aligned only
        logic             lower;
    } t_job;

    typedef enum logic [3:0] {
        BK_IDLE,
        BK_DIV,
        BK_PLAN,
        BK_PAD_LEAD,
        BK_SIGN,
        BK_PAD_ZERO,
        BK_ZEROS,
        BK_DIGITS,
        BK_PAD_TAIL,
        BK_EMPTY
    } t_bk_state;

    function automatic logic [7:0] dig_char(input logic [3:0] d, input logic lower);
        return lower ? LOWER_DIGITS[d] : UPPER_DIGITS[d];
    endfunction

endpackage
`default_nettype wire

// File: hw/rtl/itpa_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itpa_front
// Config registers and per-item classification: sign, magnitude, layout bits.
// ----------------------------------------------------------------------------
module itpa_front import itpa_pkg::*; #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD  = 60
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_cfg_valid,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [CFG_W-1:0]     i_cfg_data,
    input  wire logic [MAG_W-1:0]     i_raw_value,
    output t_job                      o_job
);

    localparam logic [5:0] FIELD_CAP = 6'(MAX_FIELD);

    logic [4:0] r_base;
    logic [6:0] r_flags;
    logic [5:0] r_min_width;
    logic [5:0] r_precision;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_base      <= BASE_RESET;
            r_flags     <= '0;
            r_min_width <= '0;
            r_precision <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_BASE:      r_base      <= i_cfg_data[4:0];
                CFG_FLAGS:     r_flags     <= i_cfg_data[6:0];
                CFG_MIN_WIDTH: r_min_width <= i_cfg_data[5:0];
                CFG_PRECISION: r_precision <= i_cfg_data[5:0];
                default: ;
            endcase
        end
    end

    logic [VALUE_BITS-1:0] v;
    logic [VALUE_BITS-1:0] mag;
    logic                  uns;
    logic                  plus;
    logic                  space;
    logic                  neg;
    logic [5:0]            prec_sat;

    always_comb begin
        uns      = r_flags[FLAG_UNSIGNED];
        plus     = r_flags[FLAG_PLUS];
        space    = r_flags[FLAG_SPACE];
        v        = i_raw_value[VALUE_BITS-1:0];
        neg      = !uns && v[VALUE_BITS-1];
        mag      = neg ? (~v + 1'b1) : v;
        prec_sat = (r_precision > FIELD_CAP) ? FIELD_CAP : r_precision;

        o_job.mag      = MAG_W'(mag);
        o_job.base     = (r_base < BASE_MIN) ? BASE_MIN :
                         ((r_base > BASE_MAX) ? BASE_MAX : r_base);
        o_job.width    = (r_min_width > FIELD_CAP) ? FIELD_CAP : r_min_width;
        o_job.prec     = r_flags[FLAG_PREC] ? prec_sat : 6'd0;
        o_job.skip     = r_flags[FLAG_PREC] && (prec_sat == 6'd0) && (mag == '0);
        o_job.has_sign = neg || (!uns && (plus || space));
        o_job.sign_ch  = neg ? CHAR_MINUS : (plus ? CHAR_PLUS : CHAR_SPACE);
        o_job.left     = r_flags[FLAG_LEFT];
        // right aligned: plus/space hold a slot even when unsigned
        o_job.slot     = r_flags[FLAG_LEFT] ? o_job.has_sign : (neg || plus || space);
        o_job.zpad     = r_flags[FLAG_ZPAD] && !r_flags[FLAG_LEFT];
        o_job.lower    = r_flags[FLAG_LOWER];
    end

endmodule
`default_nettype wire

// File: hw/rtl/itpa_queue.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itpa_queue
// Two-entry job queue between the classifier and the formatter.
// ----------------------------------------------------------------------------
module itpa_queue import itpa_pkg::*; (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_push,
    input  wire t_job i_job,
    output logic      o_not_full,
    input  wire logic i_pop,
    output logic      o_valid,
    output t_job      o_job
);

    t_job       r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_cnt;

    assign o_not_full = (r_cnt != 2'd2);
    assign o_valid    = (r_cnt != 2'd0);
    assign o_job      = r_mem[r_rp];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push && o_not_full) begin
                r_wp <= ~r_wp;
            end
            if (i_pop && o_valid) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push && o_not_full) - 2'(i_pop && o_valid);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push && o_not_full) begin
            r_mem[r_wp] <= i_job;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/itpa_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// itpa_back
// Digit generation by repeated division, then character sequencing into a
// one-deep output register.
// ----------------------------------------------------------------------------
module itpa_back import itpa_pkg::*; #(
    parameter int VALUE_BITS = 32
) (
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_job_valid,
    input  wire t_job i_job,
    output logic      o_job_pop,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    output logic [7:0] o_out_char,
    output logic      o_out_last,
    output logic      o_out_empty
);

    localparam int CHUNKS = (VALUE_BITS + 7) / 8;
    localparam int DW     = CHUNKS * 8;
    localparam int CW     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
    localparam int IDX_W  = $clog2(VALUE_BITS);
    localparam int ND_W   = $clog2(VALUE_BITS + 1);
    localparam logic [CW-1:0] LAST_CHUNK = CW'(CHUNKS - 1);

    t_bk_state       r_state, n_state;
    t_job            r_job;
    logic [DW-1:0]   r_work;
    logic [3:0]      r_rem;
    logic [CW-1:0]   r_chunk;
    logic [ND_W-1:0] r_nd;
    logic [3:0]      r_dig [VALUE_BITS];
    logic [5:0]      r_pad;
    logic [5:0]      r_zero;
    logic [ND_W-1:0] r_dsel;
    logic            r_sign_pend;
    logic [6:0]      r_remain;
    logic            r_out_valid;
    logic [7:0]      r_out_char;
    logic            r_out_last;
    logic            r_out_empty;

    logic            slot_free;
    assign slot_free = !r_out_valid || i_out_ready;

    // ---- one byte of long division per cycle, restoring, MSB first
    logic [7:0]    top_byte;
    logic [7:0]    qbyte;
    logic [3:0]    rem_new;
    logic [DW-1:0] n_work;

    always_comb begin
        logic [4:0] t;
        logic [3:0] r;
        top_byte = r_work[DW-1 -: 8];
        r        = r_rem;
        qbyte    = '0;
        for (int i = 7; i >= 0; i--) begin
            t = {r, top_byte[i]};
            if (t >= r_job.base) begin
                t        = t - r_job.base;
                qbyte[i] = 1'b1;
            end
            r = t[3:0];
        end
        rem_new = r;
        n_work  = DW'({r_work, qbyte});
    end

    // ---- layout plan once the digit count is known
    logic [6:0] nd7, p7, g7, zeros7, body7, j7, pad7, total7;

    always_comb begin
        nd7    = 7'(r_nd);
        p7     = 7'(r_job.prec);
        g7     = 7'(r_job.width);
        zeros7 = (p7 > nd7) ? (p7 - nd7) : 7'd0;
        body7  = zeros7 + nd7;
        j7     = body7 + 7'(r_job.slot);
        pad7   = (g7 > j7) ? (g7 - j7) : 7'd0;
        total7 = pad7 + 7'(r_job.has_sign) + body7;
    end

    // ---- emit decode
    logic            act;
    logic            emit;
    logic [7:0]      emit_char;
    logic            emit_empty;
    logic [ND_W-1:0] dsel_m1;

    always_comb begin
        dsel_m1    = r_dsel - 1'b1;
        act        = 1'b0;
        emit_char  = CHAR_NONE;
        emit_empty = 1'b0;
        case (r_state)
            BK_PAD_LEAD: begin
                act       = !r_job.left && !r_job.zpad && (r_pad != 6'd0);
                emit_char = CHAR_SPACE;
            end
            BK_SIGN: begin
                act       = r_sign_pend;
                emit_char = r_job.sign_ch;
            end
            BK_PAD_ZERO: begin
                act       = r_job.zpad && (r_pad != 6'd0);
                emit_char = CHAR_ZERO;
            end
            BK_ZEROS: begin
                act       = (r_zero != 6'd0);
                emit_char = CHAR_ZERO;
            end
            BK_DIGITS: begin
                act       = (r_dsel != '0);
                emit_char = dig_char(r_dig[dsel_m1[IDX_W-1:0]], r_job.lower);
            end
            BK_PAD_TAIL: begin
                act       = r_job.left && (r_pad != 6'd0);
                emit_char = CHAR_SPACE;
            end
            BK_EMPTY: begin
                act        = 1'b1;
                emit_empty = 1'b1;
            end
            default: act = 1'b0;
        endcase
        emit      = act && slot_free;
        o_job_pop = (r_state == BK_IDLE) && i_job_valid;
    end

    // ---- next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    n_state = i_job.skip ? BK_PLAN : BK_DIV;
                end
            end
            BK_DIV: begin
                if (r_chunk == LAST_CHUNK && n_work == '0) begin
                    n_state = BK_PLAN;
                end
            end
            BK_PLAN: n_state = (total7 == 7'd0) ? BK_EMPTY : BK_PAD_LEAD;
            BK_EMPTY: begin
                if (emit) begin
                    n_state = BK_IDLE;
                end
            end
            BK_PAD_LEAD, BK_SIGN, BK_PAD_ZERO, BK_ZEROS, BK_DIGITS, BK_PAD_TAIL: begin
                if (emit && r_remain == 7'd1) begin
                    n_state = BK_IDLE;
                end else if (!act) begin
                    case (r_state)
                        BK_PAD_LEAD: n_state = BK_SIGN;
                        BK_SIGN:     n_state = BK_PAD_ZERO;
                        BK_PAD_ZERO: n_state = BK_ZEROS;
                        BK_ZEROS:    n_state = BK_DIGITS;
                        BK_DIGITS:   n_state = BK_PAD_TAIL;
                        default:     n_state = BK_IDLE;
                    endcase
                end
            end
            default: n_state = BK_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= BK_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (slot_free) begin
                r_out_valid <= emit;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_char  <= emit_char;
            r_out_last  <= emit_empty || (r_remain == 7'd1);
            r_out_empty <= emit_empty;
        end
        case (r_state)
            BK_IDLE: begin
                if (i_job_valid) begin
                    r_job   <= i_job;
                    r_work  <= i_job.mag[DW-1:0];
                    r_rem   <= '0;
                    r_chunk <= '0;
                    r_nd    <= '0;
                end
            end
            BK_DIV: begin
                r_work <= n_work;
                if (r_chunk == LAST_CHUNK) begin
                    r_dig[r_nd[IDX_W-1:0]] <= rem_new;
                    r_nd    <= r_nd + 1'b1;
                    r_chunk <= '0;
                    r_rem   <= '0;
                end else begin
                    r_chunk <= r_chunk + 1'b1;
                    r_rem   <= rem_new;
                end
            end
            BK_PLAN: begin
                r_pad       <= 6'(pad7);
                r_zero      <= 6'(zeros7);
                r_dsel      <= r_nd;
                r_sign_pend <= r_job.has_sign;
                r_remain    <= total7;
            end
            default: begin
                if (emit && r_state != BK_EMPTY) begin
                    r_remain <= r_remain - 1'b1;
                    case (r_state)
                        BK_PAD_LEAD, BK_PAD_ZERO, BK_PAD_TAIL: r_pad <= r_pad - 1'b1;
                        BK_SIGN:   r_sign_pend <= 1'b0;
                        BK_ZEROS:  r_zero <= r_zero - 1'b1;
                        BK_DIGITS: r_dsel <= dsel_m1;
                        default: ;
                    endcase
                end
            end
        endcase
    end

    assign o_out_valid = r_out_valid;
    assign o_out_char  = r_out_char;
    assign o_out_last  = r_out_last;
    assign o_out_empty = r_out_empty;

    // ---- checks
    a_remain_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_PAD_LEAD || r_state == BK_SIGN || r_state == BK_PAD_ZERO ||
         r_state == BK_ZEROS || r_state == BK_DIGITS || r_state == BK_PAD_TAIL) |->
        (7'(r_pad) + 7'(r_sign_pend) + 7'(r_zero) + 7'(r_dsel) == r_remain))
        else $error("remaining count out of step with segment counters");

    a_digits_bounded: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> (r_nd < ND_W'(VALUE_BITS)))
        else $error("digit buffer overrun");

    a_rem_below_base: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == BK_DIV) |-> (5'(r_rem) < r_job.base))
        else $error("partial remainder not below base");

    a_empty_is_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out_empty) |-> r_out_last)
        else $error("empty marker without last");

endmodule
`default_nettype wire

// File: hw/rtl/integer_to_padded_ascii.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// integer_to_padded_ascii
// printf-style integer formatter: one value in, its text out one character
// per item, with sign, precision zeros, base 2..16 digits and width padding.
// ----------------------------------------------------------------------------
//
//  Channel   Direction  Payload                         Accepted when
//  --------  ---------  ------------------------------  ---------------------------
//  s_axis    in         tdata = raw_value[31:0]         s_axis_tvalid & s_axis_tready
//  m_axis    out        tdata = out_char, tlast = last, m_axis_tvalid & m_axis_tready
//                       tuser = is_empty
//  cfg       in         i_cfg_index, i_cfg_data         i_cfg_valid (always ready)
//
//  The division unit retires one byte of the dividend per cycle, producing
//  one digit per pass over the dividend; characters then leave at one per
//  cycle while m_axis is ready, and each skipped text segment costs an
//  extra state step. Characters pass through a one-deep output register.
//  Reset: synchronous, active low; registers return to base 10, no flags,
//  width 0, precision 0. No clearing pass is needed.
//  Stalls: a two-entry queue lets up to two values be taken while the
//  formatter is busy; a stalled m_axis holds the current character.
//
module integer_to_padded_ascii import itpa_pkg::*; #(
    parameter int VALUE_BITS = 32,
    parameter int MAX_FIELD  = 60
) (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    // input values
    input  wire logic                 s_axis_tvalid,
    output logic                      s_axis_tready,
    input  wire logic [31:0]          s_axis_tdata,   // [31:0] raw_value
    // formatted characters
    output logic                      m_axis_tvalid,
    input  wire logic                 m_axis_tready,
    output logic [7:0]                m_axis_tdata,   // [7:0] out_char
    output logic                      m_axis_tlast,   // last character of a value
    output logic                      m_axis_tuser,   // [0] is_empty
    // configuration writes
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,    // 0 base, 1 flags, 2 width, 3 precision
    input  wire logic [CFG_W-1:0]     i_cfg_data
);

    t_job front_job;
    t_job q_job;
    logic q_not_full;
    logic q_valid;
    logic q_pop;

    // Registers are simple flops; a write always lands in its cycle.
    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = q_not_full;

    // Front: config registers and classification of each incoming value.
    itpa_front #(
        .VALUE_BITS (VALUE_BITS),
        .MAX_FIELD  (MAX_FIELD)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_raw_value (s_axis_tdata),
        .o_job       (front_job)
    );

    // Decouples acceptance from the slow digit loop.
    itpa_queue u_queue (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_push     (s_axis_tvalid),
        .i_job      (front_job),
        .o_not_full (q_not_full),
        .i_pop      (q_pop),
        .o_valid    (q_valid),
        .o_job      (q_job)
    );

    // Back: digit generation and character sequencing.
    itpa_back #(
        .VALUE_BITS (VALUE_BITS)
    ) u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_valid (q_valid),
        .i_job       (q_job),
        .o_job_pop   (q_pop),
        .o_out_valid (m_axis_tvalid),
        .i_out_ready (m_axis_tready),
        .o_out_char  (m_axis_tdata),
        .o_out_last  (m_axis_tlast),
        .o_out_empty (m_axis_tuser)
    );

endmodule
`default_nettype wire
